// ===== sv/pdc_pkg.sv =====
// shared types, constants and weight helpers for the pixel grade block
package pdc_pkg;

	// channel levels in Q8 (code times 256)
	localparam logic [15:0] CH_MID_Q8 = 16'd32640;
	localparam logic [15:0] CH_ONE_Q8 = 16'd65280;

	// luma weights in Q0.16, sum 65536
	localparam logic [15:0] LUMA_WR = 16'd13933;
	localparam logic [15:0] LUMA_WG = 16'd46871;
	localparam logic [15:0] LUMA_WB = 16'd4732;

	// 2^20 / 50 rounded up, exact floor for numerators below 25650
	localparam logic [14:0] RECIP_50 = 15'd20972;

	// register indexes of the configuration port
	typedef enum logic [1:0] {
		REG_SAT = 2'd0,
		REG_PRI = 2'd1,
		REG_CON = 2'd2
	} reg_idx_t;

	// mix weights and contrast scale, Q8
	typedef struct packed {
		logic [8:0] w1;
		logic [8:0] w2;
		logic [9:0] k;
	} weights_t;

	// sign-extend a 7-bit register value and saturate to -50..50
	function automatic logic signed [7:0] pct_clamp(input logic [6:0] raw);
		logic signed [7:0] v;
		v = $signed({raw[6], raw});
		if (v < -8'sd50) begin
			v = -8'sd50;
		end else if (v > 8'sd50) begin
			v = 8'sd50;
		end
		pct_clamp = v;
	endfunction

	// round(256*p/50) half up for p in -100..100, zero for p <= 0
	function automatic logic [9:0] pct_weight(input logic signed [7:0] p);
		logic [14:0] n;
		logic [29:0] prod;
		n = {p[6:0], 8'b0} + 15'd25;
		prod = n * RECIP_50;
		if (p <= 8'sd0) begin
			pct_weight = 10'd0;
		end else begin
			pct_weight = prod[29:20];
		end
	endfunction

endpackage

// ===== sv/pdc_if.sv =====
// stream interfaces for incoming and graded pixels
interface pdc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_red;
	logic [7:0] in_green;
	logic [7:0] in_blue;
	logic [7:0] in_alpha;

	modport source (output valid, in_red, in_green, in_blue, in_alpha, input ready);
	modport sink (input valid, in_red, in_green, in_blue, in_alpha, output ready);
endinterface

interface pdc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic [7:0] out_alpha;

	modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
	modport sink (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

// ===== sv/pdc_cfg.sv =====
// configuration registers, kept as ready-to-use mix weights
module pdc_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_idx,
	input  logic [6:0]          cfg_data,
	output pdc_pkg::weights_t   weights
);

	logic signed [7:0] pct;
	logic signed [7:0] pos_arg;
	logic signed [7:0] neg_arg;
	logic [9:0]        pos_w;
	logic [9:0]        neg_w;
	logic [8:0]        sat_w_q;
	logic [8:0]        sat_neg_w_q;
	logic [8:0]        pri_w_q;
	logic [9:0]        k_q;

	// weights are computed from the write data as it arrives
	always_comb begin
		pct = pdc_pkg::pct_clamp(cfg_data);
		neg_arg = -pct;
		pos_arg = (cfg_idx == pdc_pkg::REG_CON) ? (pct + 8'sd50) : pct;
		pos_w = pdc_pkg::pct_weight(pos_arg);
		neg_w = pdc_pkg::pct_weight(neg_arg);
	end

	// register file, reset state is all percentages zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_w_q     <= '0;
			sat_neg_w_q <= '0;
			pri_w_q     <= '0;
			k_q         <= 10'd256;
		end else if (cfg_we) begin
			case (cfg_idx)
				pdc_pkg::REG_SAT: begin
					sat_w_q     <= pos_w[8:0];
					sat_neg_w_q <= neg_w[8:0];
				end
				pdc_pkg::REG_PRI: begin
					pri_w_q <= pos_w[8:0];
				end
				pdc_pkg::REG_CON: begin
					k_q <= pos_w;
				end
				default: begin
				end
			endcase
		end
	end

	// green pull uses the larger of the two positive amounts
	assign weights.w1 = (sat_w_q > pri_w_q) ? sat_w_q : pri_w_q;
	assign weights.w2 = sat_neg_w_q;
	assign weights.k  = k_q;

`ifndef SYNTHESIS
	a_weight_range: assert property (@(posedge clk) disable iff (!arst_n)
		(k_q <= 10'd512) && (sat_w_q <= 9'd256) && (pri_w_q <= 9'd256)
		&& (sat_neg_w_q <= 9'd256))
		else $error("weight register out of range");
	a_sat_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!((sat_w_q != 9'd0) && (sat_neg_w_q != 9'd0)))
		else $error("saturation pulls both ways at once");
`endif

endmodule

// ===== sv/pdc_pipe.sv =====
// four-stage grading pipeline: green pull, luma, desaturate, contrast
module pdc_pipe (
	input  logic              clk,
	input  logic              arst_n,
	input  pdc_pkg::weights_t weights,
	pdc_in_if.sink            pix_in,
	pdc_out_if.source         pix_out
);

	// mix x toward t by w/256, rounded half up
	function automatic logic [15:0] blend(input logic [15:0] x, input logic [15:0] t,
			input logic [8:0] w);
		logic [23:0] s;
		s = x * (9'd256 - w) + t * w + 24'd128;
		blend = s[23:8];
	endfunction

	// scale about mid grey by k/256, clamp and round to an 8-bit code
	function automatic logic [7:0] grade(input logic [15:0] x, input logic [9:0] k);
		logic signed [16:0] d;
		logic signed [27:0] p;
		logic signed [19:0] v;
		logic [15:0]        c;
		logic [15:0]        r;
		d = $signed({1'b0, x}) - $signed({1'b0, pdc_pkg::CH_MID_Q8});
		p = d * $signed({1'b0, k});
		p = p + 28'sd128;
		v = 20'(p >>> 8) + $signed({4'b0, pdc_pkg::CH_MID_Q8});
		if (v < 20'sd0) begin
			c = 16'd0;
		end else if (v > $signed({4'b0, pdc_pkg::CH_ONE_Q8})) begin
			c = pdc_pkg::CH_ONE_Q8;
		end else begin
			c = v[15:0];
		end
		r = c + 16'd128;
		grade = r[15:8];
	endfunction

	logic        v_s1, v_s2, v_s3, v_s4;
	logic        en1, en2, en3, en4;
	logic [7:0]  r_s1, b_s1, a_s1;
	logic [15:0] g_s1;
	logic [15:0] r_s2, g_s2, b_s2, y_s2;
	logic [7:0]  a_s2;
	logic [15:0] r_s3, g_s3, b_s3;
	logic [7:0]  a_s3;
	logic [7:0]  red_s4, green_s4, blue_s4, alpha_s4;
	logic [15:0] r_in, g_in, m_in;
	logic [31:0] luma_sum;

	// stage enables, a stage loads when empty or when its contents move on
	assign en4 = !v_s4 || pix_out.ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign pix_in.ready = en1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= pix_in.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// stage 1: green toward min(red, green)
	assign r_in = {pix_in.in_red, 8'b0};
	assign g_in = {pix_in.in_green, 8'b0};
	assign m_in = (r_in < g_in) ? r_in : g_in;

	always_ff @(posedge clk) begin
		if (en1) begin
			r_s1 <= pix_in.in_red;
			b_s1 <= pix_in.in_blue;
			a_s1 <= pix_in.in_alpha;
			g_s1 <= blend(g_in, m_in, weights.w1);
		end
	end

	// stage 2: luma
	assign luma_sum = {r_s1, 8'b0} * pdc_pkg::LUMA_WR + g_s1 * pdc_pkg::LUMA_WG
		+ {b_s1, 8'b0} * pdc_pkg::LUMA_WB + 32'd32768;

	always_ff @(posedge clk) begin
		if (en2) begin
			r_s2 <= {r_s1, 8'b0};
			g_s2 <= g_s1;
			b_s2 <= {b_s1, 8'b0};
			a_s2 <= a_s1;
			y_s2 <= luma_sum[31:16];
		end
	end

	// stage 3: all channels toward luma
	always_ff @(posedge clk) begin
		if (en3) begin
			r_s3 <= blend(r_s2, y_s2, weights.w2);
			g_s3 <= blend(g_s2, y_s2, weights.w2);
			b_s3 <= blend(b_s2, y_s2, weights.w2);
			a_s3 <= a_s2;
		end
	end

	// stage 4: contrast and output codes, zero alpha gives black
	always_ff @(posedge clk) begin
		if (en4) begin
			if (a_s3 == 8'd0) begin
				red_s4   <= 8'd0;
				green_s4 <= 8'd0;
				blue_s4  <= 8'd0;
			end else begin
				red_s4   <= grade(r_s3, weights.k);
				green_s4 <= grade(g_s3, weights.k);
				blue_s4  <= grade(b_s3, weights.k);
			end
			alpha_s4 <= a_s3;
		end
	end

	assign pix_out.valid     = v_s4;
	assign pix_out.out_red   = red_s4;
	assign pix_out.out_green = green_s4;
	assign pix_out.out_blue  = blue_s4;
	assign pix_out.out_alpha = alpha_s4;

`ifndef SYNTHESIS
	a_zero_alpha_black: assert property (@(posedge clk) disable iff (!arst_n)
		pix_out.valid && (pix_out.out_alpha == 8'd0) |->
		(pix_out.out_red == 8'd0) && (pix_out.out_green == 8'd0)
		&& (pix_out.out_blue == 8'd0))
		else $error("zero-alpha item not black");
	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_in.ready |-> v_s1 && v_s2 && v_s3 && v_s4)
		else $error("input blocked with a bubble in the pipeline");
	a_stalled_luma_held: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !en2 |=> v_s2 && $stable(y_s2) && $stable(g_s2))
		else $error("stalled luma stage lost its item");
`endif

endmodule

// ===== sv/pixel_desaturate_contrast.sv =====
// top level of the pixel desaturate and contrast grade
//
//  channel   dir   payload                                   handshake
//  pix_in    in    in_red, in_green, in_blue, in_alpha       valid/ready
//  pix_out   out   out_red, out_green, out_blue, out_alpha   valid/ready
//  cfg       in    cfg_idx (2b), cfg_data (7b)               cfg_we, no wait
//
// one pixel per clock sustained while pix_out is ready; an accepted pixel passes
// through the four register stages (green pull, luma, luma mix, contrast) in order
// before out valid rises
// arst_n clears all valid bits and sets every percentage to zero
// a stall on pix_out backs up stage by stage; empty stages keep filling meanwhile
// a config write takes effect at the next clock edge
module pixel_desaturate_contrast (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_idx,
	input  logic [6:0] cfg_data,
	pdc_in_if.sink     pix_in,
	pdc_out_if.source  pix_out
);

	pdc_pkg::weights_t weights;

	// configuration registers
	pdc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.weights  (weights)
	);

	// grading pipeline
	pdc_pipe u_pipe (
		.clk     (clk),
		.arst_n  (arst_n),
		.weights (weights),
		.pix_in  (pix_in),
		.pix_out (pix_out)
	);

endmodule
